// File: rtl/sndlog_pkg.sv
// Shared definitions for the sound log command parser.
// Command codes, parse phases, result kinds and the result word type.
// No dependencies.
`timescale 1ns / 1ps

package sndlog_pkg;

  localparam int POS_BITS_DEFAULT = 32;
  localparam logic [31:0] START_OFFSET_RESET = 32'd64;

  localparam logic [7:0] CMD_PSG       = 8'h50;
  localparam logic [7:0] CMD_FM0       = 8'h52;
  localparam logic [7:0] CMD_FM1       = 8'h53;
  localparam logic [7:0] CMD_WAIT_ARG  = 8'h61;
  localparam logic [7:0] CMD_WAIT_NTSC = 8'h62;
  localparam logic [7:0] CMD_WAIT_PAL  = 8'h63;
  localparam logic [7:0] CMD_END       = 8'h66;
  localparam logic [7:0] CMD_BLOCK     = 8'h67;
  localparam logic [7:0] CMD_SEEK      = 8'he0;
  localparam logic [3:0] GRP_SHORT_WAIT = 4'h7;
  localparam logic [3:0] GRP_DAC        = 4'h8;

  localparam logic [15:0] WAIT_NTSC = 16'd735;
  localparam logic [15:0] WAIT_PAL  = 16'd882;
  localparam logic [7:0]  DAC_REG   = 8'h2a;

  localparam logic [3:0] PH_IDLE  = 4'd0;
  localparam logic [3:0] PH_PSG   = 4'd1;
  localparam logic [3:0] PH_FMREG = 4'd2;
  localparam logic [3:0] PH_FMDAT = 4'd3;
  localparam logic [3:0] PH_WAIT  = 4'd4;
  localparam logic [3:0] PH_BLOCK = 4'd5;
  localparam logic [3:0] PH_SEEK  = 4'd6;
  localparam logic [3:0] PH_SKIP1 = 4'd7;
  localparam logic [3:0] PH_SKIPN = 4'd8;

  localparam logic [2:0] KIND_PSG  = 3'd0;
  localparam logic [2:0] KIND_FM   = 3'd1;
  localparam logic [2:0] KIND_WAIT = 3'd2;
  localparam logic [2:0] KIND_DAC  = 3'd3;
  localparam logic [2:0] KIND_END  = 3'd4;
  localparam logic [2:0] KIND_UNK  = 3'd5;

  localparam logic [2:0] CNT_WAIT_LAST  = 3'd1;
  localparam logic [2:0] CNT_SIZE_FIRST = 3'd2;
  localparam logic [2:0] CNT_BLOCK_LAST = 3'd5;
  localparam logic [2:0] CNT_SEEK_LAST  = 3'd3;

  typedef struct packed {
    logic [2:0]  kind;
    logic        fm_port;
    logic [7:0]  reg_addr;
    logic [7:0]  reg_value;
    logic [15:0] wait_samples;
    logic [31:0] pcm_address;
  } sndlog_result_t;

endpackage

// File: rtl/sndlog_core.sv
// Parser state and per-byte decode for the sound log command parser.
// Updates state on each accepted byte and presents its result combinationally.
// Depends on sndlog_pkg.
`timescale 1ns / 1ps

module sndlog_core #(
  parameter int POS_BITS = sndlog_pkg::POS_BITS_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    byte_valid,
  input  logic [7:0]              byte_data,
  input  logic                    cfg_we,
  input  logic [31:0]             cfg_data,
  output logic                    res_valid,
  output sndlog_pkg::sndlog_result_t res
);
  import sndlog_pkg::*;

  logic [3:0]          phase, phase_next;
  logic [7:0]          held_command, held_command_next;
  logic [2:0]          arg_count, arg_count_next;
  logic [31:0]         arg_shift, arg_shift_next;
  logic [POS_BITS-1:0] stream_pos, stream_pos_next;
  logic [POS_BITS-1:0] data_start, data_start_next;
  logic [31:0]         pcm_base, pcm_base_next;
  logic [31:0]         pcm_step, pcm_step_next;
  logic [31:0]         skip_left, skip_left_next;
  logic                stream_done, stream_done_next;

  logic [2:0]  gather_idx;
  logic [31:0] gathered;
  logic [31:0] skip_dec;

  always_comb begin
    gather_idx = (phase == PH_BLOCK) ? (arg_count - CNT_SIZE_FIRST) : arg_count;
    gathered   = arg_shift | ({24'b0, byte_data} << {gather_idx[1:0], 3'b000});
    skip_dec   = (skip_left != 32'd0) ? (skip_left - 32'd1) : skip_left;
  end

  always_comb begin
    phase_next        = phase;
    held_command_next = held_command;
    arg_count_next    = arg_count;
    arg_shift_next    = arg_shift;
    stream_pos_next   = stream_pos;
    data_start_next   = data_start;
    pcm_base_next     = pcm_base;
    pcm_step_next     = pcm_step;
    skip_left_next    = skip_left;
    stream_done_next  = stream_done;
    res_valid         = 1'b0;
    res               = '0;
    if (byte_valid && !stream_done) begin
      stream_pos_next = stream_pos + POS_BITS'(1);
      case (phase)
        PH_IDLE: begin
          held_command_next = byte_data;
          arg_count_next    = 3'd0;
          arg_shift_next    = 32'd0;
          if (byte_data == CMD_PSG) begin
            phase_next = PH_PSG;
          end else if (byte_data inside {CMD_FM0, CMD_FM1}) begin
            phase_next = PH_FMREG;
          end else if (byte_data == CMD_WAIT_ARG) begin
            phase_next = PH_WAIT;
          end else if (byte_data == CMD_WAIT_NTSC) begin
            res_valid        = 1'b1;
            res.kind         = KIND_WAIT;
            res.wait_samples = WAIT_NTSC;
          end else if (byte_data == CMD_WAIT_PAL) begin
            res_valid        = 1'b1;
            res.kind         = KIND_WAIT;
            res.wait_samples = WAIT_PAL;
          end else if (byte_data == CMD_END) begin
            stream_done_next = 1'b1;
            res_valid        = 1'b1;
            res.kind         = KIND_END;
          end else if (byte_data == CMD_BLOCK) begin
            phase_next = PH_BLOCK;
          end else if (byte_data[7:4] == GRP_SHORT_WAIT) begin
            res_valid        = 1'b1;
            res.kind         = KIND_WAIT;
            res.wait_samples = {12'b0, byte_data[3:0]} + 16'd1;
          end else if (byte_data[7:4] == GRP_DAC) begin
            res_valid        = 1'b1;
            res.kind         = KIND_DAC;
            res.reg_addr     = DAC_REG;
            res.wait_samples = {12'b0, byte_data[3:0]};
            res.pcm_address  = 32'(data_start) + pcm_base + pcm_step;
            pcm_step_next    = pcm_step + 32'd1;
          end else if (byte_data == CMD_SEEK) begin
            phase_next = PH_SEEK;
          end else begin
            res_valid     = 1'b1;
            res.kind      = KIND_UNK;
            res.reg_value = byte_data;
            phase_next    = PH_SKIP1;
          end
        end
        PH_PSG: begin
          res_valid     = 1'b1;
          res.kind      = KIND_PSG;
          res.reg_value = byte_data;
          phase_next    = PH_IDLE;
        end
        PH_FMREG: begin
          arg_shift_next = {24'b0, byte_data};
          phase_next     = PH_FMDAT;
        end
        PH_FMDAT: begin
          res_valid     = 1'b1;
          res.kind      = KIND_FM;
          res.fm_port   = held_command[0];
          res.reg_addr  = arg_shift[7:0];
          res.reg_value = byte_data;
          phase_next    = PH_IDLE;
        end
        PH_WAIT: begin
          arg_shift_next = gathered;
          arg_count_next = arg_count + 3'd1;
          if (arg_count == CNT_WAIT_LAST) begin
            res_valid        = 1'b1;
            res.kind         = KIND_WAIT;
            res.wait_samples = gathered[15:0];
            phase_next       = PH_IDLE;
          end
        end
        PH_BLOCK: begin
          if (arg_count >= CNT_SIZE_FIRST) begin
            arg_shift_next = gathered;
          end
          arg_count_next = arg_count + 3'd1;
          if (arg_count == CNT_BLOCK_LAST) begin
            data_start_next = stream_pos + POS_BITS'(1);
            skip_left_next  = gathered;
            phase_next      = (gathered != 32'd0) ? PH_SKIPN : PH_IDLE;
          end
        end
        PH_SEEK: begin
          arg_shift_next = gathered;
          arg_count_next = arg_count + 3'd1;
          if (arg_count == CNT_SEEK_LAST) begin
            pcm_base_next = gathered;
            pcm_step_next = 32'd0;
            phase_next    = PH_IDLE;
          end
        end
        PH_SKIP1: begin
          phase_next = PH_IDLE;
        end
        PH_SKIPN: begin
          skip_left_next = skip_dec;
          if (skip_dec == 32'd0) begin
            phase_next = PH_IDLE;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
    if (cfg_we) begin
      stream_pos_next = cfg_data[POS_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      held_command <= 8'd0;
      arg_count    <= 3'd0;
      arg_shift    <= 32'd0;
      stream_pos   <= START_OFFSET_RESET[POS_BITS-1:0];
      data_start   <= '0;
      pcm_base     <= 32'd0;
      pcm_step     <= 32'd0;
      skip_left    <= 32'd0;
      stream_done  <= 1'b0;
    end else begin
      phase        <= phase_next;
      held_command <= held_command_next;
      arg_count    <= arg_count_next;
      arg_shift    <= arg_shift_next;
      stream_pos   <= stream_pos_next;
      data_start   <= data_start_next;
      pcm_base     <= pcm_base_next;
      pcm_step     <= pcm_step_next;
      skip_left    <= skip_left_next;
      stream_done  <= stream_done_next;
    end
  end

endmodule

// File: rtl/sound_log_command_parser.sv
// Top level of the sound log command parser: stream ports, config port,
// registered result with a skid stage. Depends on sndlog_pkg, sndlog_core.
//
//   channel   | direction | word
//   s_axis    | in        | tdata[7:0] stream_byte
//   m_axis    | out       | tuser[2:0] kind, tdata fields listed at the port
//   cfg       | in        | cfg_data[31:0] start_offset
//
// One byte per cycle unless stalled; a command's last byte registers its result.
// The result register and one skid entry hold results while m_axis stalls;
// s_axis_tready drops only while the skid entry is full.
// Reset is synchronous and returns to idle with the position at offset 64.
// cfg_ready is always high; a write reloads the stream position.
`timescale 1ns / 1ps

module sound_log_command_parser #(
  parameter int POS_BITS = sndlog_pkg::POS_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] stream_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] fm_port, [8:1] reg_addr, [16:9] reg_value, [32:17] wait_samples,
  // [64:33] pcm_address, [71:65] zero
  output logic [71:0] m_axis_tdata,
  output logic [2:0]  m_axis_tuser,  // [2:0] kind
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);
  import sndlog_pkg::*;

  logic           accept;
  logic           res_valid;
  sndlog_result_t res;
  sndlog_result_t out_word, skid_word;
  logic           out_valid, skid_valid;
  logic           pop;

  assign s_axis_tready = !skid_valid;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;
  assign pop           = out_valid && m_axis_tready;

  sndlog_core #(
    .POS_BITS(POS_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .byte_valid(accept),
    .byte_data (s_axis_tdata),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_word   <= skid_word;
        skid_valid <= 1'b0;
      end
    end else if (accept && res_valid) begin
      if (!out_valid || pop) begin
        out_word  <= res;
        out_valid <= 1'b1;
      end else begin
        skid_word  <= res;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_word.kind;
  assign m_axis_tdata  = {7'b0, out_word.pcm_address, out_word.wait_samples,
                          out_word.reg_value, out_word.reg_addr, out_word.fm_port};

endmodule

// File: rtl/sndlog_checker.sv
// Port-level checks for the sound log command parser, bound to the top level.
// Depends on sndlog_pkg and sound_log_command_parser.
`timescale 1ns / 1ps

module sndlog_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);
  import sndlog_pkg::*;

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word dropped while stalled");

  a_hold_word: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result word changed");

  a_rise_needs_input: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
    else $error("result word without an accepted input word");

  a_dac_reg: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == KIND_DAC |-> m_axis_tdata[16:0] == {8'd0, DAC_REG, 1'b0})
    else $error("dac fetch with wrong register or data");

  a_addr_only_dac: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != KIND_DAC |-> m_axis_tdata[71:33] == 39'd0)
    else $error("pcm address set on a non-dac result");

endmodule

bind sound_log_command_parser sndlog_checker u_sndlog_checker (.*);

// File: sim/tb_sound_log_command_parser.sv
// Self-checking testbench for sound_log_command_parser: feeds command-log bytes
// and checks every result word against a byte-level model of the parser.
// Depends on sndlog_pkg and the sound_log_command_parser RTL.
`timescale 1ns / 1ps

module tb_sound_log_command_parser;
  import sndlog_pkg::*;

  class sndlog_scoreboard;
    sndlog_result_t expected_q[$];
    int unsigned    mismatches;

    logic [3:0]  phase;
    logic [7:0]  held_cmd;
    int unsigned arg_count;
    logic [31:0] arg_word;
    logic [31:0] pos;
    logic [31:0] data_start;
    logic [31:0] pcm_base;
    logic [31:0] pcm_step;
    logic [31:0] skip_left;
    bit          finished;

    function new();
      mismatches = 0;
      phase      = PH_IDLE;
      held_cmd   = 8'h00;
      arg_count  = 0;
      arg_word   = 32'h0;
      pos        = START_OFFSET_RESET;
      data_start = 32'h0;
      pcm_base   = 32'h0;
      pcm_step   = 32'h0;
      skip_left  = 32'h0;
      finished   = 1'b0;
    endfunction

    function void load_offset(logic [31:0] offset);
      pos = offset;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void add(logic [2:0] kind, logic port, logic [7:0] addr, logic [7:0] val,
                      logic [15:0] samples, logic [31:0] pcm);
      sndlog_result_t r;
      r.kind         = kind;
      r.fm_port      = port;
      r.reg_addr     = addr;
      r.reg_value    = val;
      r.wait_samples = samples;
      r.pcm_address  = pcm;
      expected_q.push_back(r);
    endfunction

    function void gather(logic [7:0] b, int unsigned idx);
      arg_word = arg_word | ({24'h0, b} << (8 * (idx % 4)));
    endfunction

    function void note_byte(logic [7:0] b);
      logic [31:0] here;
      here = pos;
      if (finished) return;
      pos = pos + 32'd1;
      case (phase)
        PH_IDLE: begin
          held_cmd  = b;
          arg_count = 0;
          arg_word  = 32'h0;
          if (b == CMD_PSG) begin
            phase = PH_PSG;
          end else if (b == CMD_FM0 || b == CMD_FM1) begin
            phase = PH_FMREG;
          end else if (b == CMD_WAIT_ARG) begin
            phase = PH_WAIT;
          end else if (b == CMD_WAIT_NTSC) begin
            add(KIND_WAIT, 1'b0, 8'h00, 8'h00, WAIT_NTSC, 32'h0);
          end else if (b == CMD_WAIT_PAL) begin
            add(KIND_WAIT, 1'b0, 8'h00, 8'h00, WAIT_PAL, 32'h0);
          end else if (b == CMD_END) begin
            finished = 1'b1;
            add(KIND_END, 1'b0, 8'h00, 8'h00, 16'h0, 32'h0);
          end else if (b == CMD_BLOCK) begin
            phase = PH_BLOCK;
          end else if (b[7:4] == GRP_SHORT_WAIT) begin
            add(KIND_WAIT, 1'b0, 8'h00, 8'h00, {12'h0, b[3:0]} + 16'd1, 32'h0);
          end else if (b[7:4] == GRP_DAC) begin
            add(KIND_DAC, 1'b0, DAC_REG, 8'h00, {12'h0, b[3:0]},
                data_start + pcm_base + pcm_step);
            pcm_step = pcm_step + 32'd1;
          end else if (b == CMD_SEEK) begin
            phase = PH_SEEK;
          end else begin
            add(KIND_UNK, 1'b0, 8'h00, b, 16'h0, 32'h0);
            phase = PH_SKIP1;
          end
        end
        PH_PSG: begin
          add(KIND_PSG, 1'b0, 8'h00, b, 16'h0, 32'h0);
          phase = PH_IDLE;
        end
        PH_FMREG: begin
          arg_word = {24'h0, b};
          phase    = PH_FMDAT;
        end
        PH_FMDAT: begin
          add(KIND_FM, held_cmd[0], arg_word[7:0], b, 16'h0, 32'h0);
          phase = PH_IDLE;
        end
        PH_WAIT: begin
          gather(b, arg_count);
          arg_count++;
          if (arg_count >= 2) begin
            add(KIND_WAIT, 1'b0, 8'h00, 8'h00, arg_word[15:0], 32'h0);
            phase = PH_IDLE;
          end
        end
        PH_BLOCK: begin
          if (arg_count >= 2) gather(b, arg_count - 2);
          arg_count++;
          if (arg_count >= 6) begin
            data_start = here + 32'd1;
            skip_left  = arg_word;
            phase      = (skip_left != 0) ? PH_SKIPN : PH_IDLE;
          end
        end
        PH_SEEK: begin
          gather(b, arg_count);
          arg_count++;
          if (arg_count >= 4) begin
            pcm_base = arg_word;
            pcm_step = 32'h0;
            phase    = PH_IDLE;
          end
        end
        PH_SKIP1: begin
          phase = PH_IDLE;
        end
        PH_SKIPN: begin
          if (skip_left != 0) skip_left = skip_left - 32'd1;
          if (skip_left == 0) phase = PH_IDLE;
        end
        default: begin
          phase = PH_IDLE;
        end
      endcase
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(sndlog_result_t got);
      sndlog_result_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result word: kind %0d", got.kind);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      check_field("kind", 32'(want.kind), 32'(got.kind));
      check_field("fm_port", 32'(want.fm_port), 32'(got.fm_port));
      check_field("reg_addr", 32'(want.reg_addr), 32'(got.reg_addr));
      check_field("reg_value", 32'(want.reg_value), 32'(got.reg_value));
      check_field("wait_samples", 32'(want.wait_samples), 32'(got.wait_samples));
      check_field("pcm_address", want.pcm_address, got.pcm_address);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] stream_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [0] fm_port, [8:1] reg_addr, [16:9] reg_value, [32:17] wait_samples,
  // [64:33] pcm_address, [71:65] zero
  logic [71:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;            // [2:0] kind
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = 32'h0;

  sndlog_scoreboard sb;
  sndlog_result_t   result_word;
  int               send_idle_pct = 0;
  int               recv_stall_pct = 0;
  int unsigned      hold_cycles = 0;
  int unsigned      hold_count = 0;
  int unsigned      bytes_sent = 0;

  sound_log_command_parser uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  assign result_word = {m_axis_tuser, m_axis_tdata[0], m_axis_tdata[8:1],
                        m_axis_tdata[16:9], m_axis_tdata[32:17], m_axis_tdata[64:33]};

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(result_word);
      if (hold_count < hold_cycles) begin
        m_axis_tready <= 1'b0;
        hold_count    <= hold_count + 1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_byte(input logic [7:0] raw, input bit as_is);
    logic [7:0] b;
    b = raw;
    // keep the stream from ending early and block payloads short
    if (!as_is) begin
      if (sb.phase == PH_IDLE && b == CMD_END) b = CMD_WAIT_PAL;
      else if (sb.phase == PH_BLOCK && sb.arg_count == 2) b = b & 8'h3f;
      else if (sb.phase == PH_BLOCK && sb.arg_count > 2) b = 8'h00;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  task automatic settle(input int extra);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_offset(input logic [31:0] offset);
    cfg_valid <= 1'b1;
    cfg_data  <= offset;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.load_offset(offset);
  endtask

  task automatic random_command();
    logic [7:0]  seq[$];
    logic [7:0]  b;
    logic [31:0] word;
    int unsigned size;
    int          r;
    if ($urandom_range(49) == 0) settle(0);
    r = $urandom_range(99);
    if (r < 8) begin
      seq.push_back(8'($urandom_range(255)));
    end else if (r < 16) begin
      do b = 8'($urandom_range(255));
      while (b == CMD_PSG || b == CMD_FM0 || b == CMD_FM1 || b == CMD_WAIT_ARG ||
             b == CMD_WAIT_NTSC || b == CMD_WAIT_PAL || b == CMD_END ||
             b == CMD_BLOCK || b == CMD_SEEK || b[7:4] == GRP_SHORT_WAIT ||
             b[7:4] == GRP_DAC);
      seq = '{b, 8'($urandom_range(255))};
    end else if (r < 26) begin
      seq = '{CMD_PSG, 8'($urandom_range(255))};
    end else if (r < 40) begin
      seq = '{($urandom_range(1) != 0) ? CMD_FM1 : CMD_FM0,
              8'($urandom_range(255)), 8'($urandom_range(255))};
    end else if (r < 48) begin
      seq = '{CMD_WAIT_ARG, 8'($urandom_range(255)), 8'($urandom_range(255))};
    end else if (r < 53) begin
      seq.push_back(($urandom_range(1) != 0) ? CMD_WAIT_PAL : CMD_WAIT_NTSC);
    end else if (r < 63) begin
      seq.push_back({GRP_SHORT_WAIT, 4'($urandom_range(15))});
    end else if (r < 83) begin
      seq.push_back({GRP_DAC, 4'($urandom_range(15))});
    end else if (r < 90) begin
      word = $urandom();
      seq = '{CMD_SEEK, word[7:0], word[15:8], word[23:16], word[31:24]};
    end else begin
      size = ($urandom_range(3) == 0) ? 0 :
             ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(6);
      seq = '{CMD_BLOCK, 8'($urandom_range(255)), 8'($urandom_range(255)),
              8'(size), 8'h00, 8'h00, 8'h00};
      repeat (size) seq.push_back(8'($urandom_range(255)));
    end
    if (seq.size() > 1 && $urandom_range(9) == 0)
      seq = seq[0:$urandom_range(seq.size() - 2)];
    foreach (seq[i]) send_byte(seq[i], 1'b0);
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned stop_at;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) random_command();
  endtask

  initial begin
    logic [7:0] directed_bytes[$];
    sb = new();
    directed_bytes = '{
      CMD_PSG, 8'hff,
      CMD_FM0, 8'h00, 8'hff,
      CMD_FM1, 8'hff, 8'h00,
      CMD_WAIT_ARG, 8'hff, 8'hff,
      CMD_WAIT_NTSC, CMD_WAIT_PAL,
      {GRP_SHORT_WAIT, 4'h0}, {GRP_SHORT_WAIT, 4'hf},
      CMD_SEEK, 8'hf0, 8'hff, 8'hff, 8'hff,
      CMD_BLOCK, CMD_END, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'haa, 8'h55,
      {GRP_DAC, 4'h0}, {GRP_DAC, 4'hf},
      8'h00, CMD_END,
      8'hff, 8'h00
    };
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_bytes[i]) send_byte(directed_bytes[i], 1'b1);
    settle(8);

    write_offset(32'h0000_0000);
    run_random(120);
    settle(8);

    send_idle_pct = 72;
    write_offset(32'hffff_ffff);
    run_random(120);
    settle(8);

    send_idle_pct  = 0;
    recv_stall_pct = 72;
    write_offset($urandom());
    run_random(120);
    settle(8);

    send_idle_pct  = 22;
    recv_stall_pct = 22;
    write_offset(32'hffff_fff0 | 32'($urandom_range(15)));
    run_random(120);
    settle(8);

    // hold the output off long enough for the input to back up
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles <= 300;
    repeat (40) send_byte({GRP_SHORT_WAIT, 4'($urandom_range(15))}, 1'b0);
    settle(8);

    send_idle_pct  = 22;
    recv_stall_pct = 22;
    write_offset($urandom());
    run_random(30);
    while (sb.phase != PH_IDLE) send_byte(8'($urandom_range(255)), 1'b0);
    send_byte(CMD_END, 1'b1);
    repeat (4) send_byte(8'($urandom_range(255)), 1'b1);
    settle(8);

    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
